// File: src/aesi_pkg.sv
// Shared types and constants for the escape-sequence interpreter.
`default_nettype none
package aesi_pkg;
  localparam int unsigned MaxParams = 16;
  localparam int unsigned ParamBits = 16;
  localparam int unsigned CntW = $clog2(MaxParams + 2);
  localparam int unsigned CfgW = 9;

  localparam logic [7:0] ChEsc = 8'd27;
  localparam logic [7:0] ChLbr = 8'h5b;
  localparam logic [7:0] ChQm = 8'h3f;
  localparam logic [7:0] ChSemi = 8'h3b;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] FinalLo = 8'd64;
  localparam logic [7:0] FinalHi = 8'd126;

  localparam logic CfgWidth = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef enum logic [2:0] {
    ActUpdate = 3'd0, ActEraseEos = 3'd1, ActEraseAll = 3'd2, ActEraseEol = 3'd3,
    ActScrollDn = 3'd4, ActDaReply = 3'd5, ActInvalid = 3'd6, ActUnhandled = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    KindBad = 2'd0, KindShort = 2'd1, KindCsi = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] seq_byte;
    logic       seq_first;
    logic       seq_last;
  } in_word_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic       attr_bold;
    logic       attr_underline;
    logic       attr_blink;
    logic       attr_reverse;
    logic       cursor_keys_app;
    logic       keypad_app;
    logic [7:0] region_top;
    logic [7:0] region_bottom;
  } out_word_t;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           fb;
    logic [CntW-1:0]      n;
    logic [ParamBits-1:0] p0;
    logic [ParamBits-1:0] p1;
    logic                 mclr;
    logic [3:0]           mset;
    logic                 mbad;
  } cmd_t;
endpackage
`default_nettype wire

// File: src/aesi_front.sv
// Byte parser: gathers parameters and issues one command per sequence.
`default_nettype none
module aesi_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire aesi_pkg::in_word_t in_word_i,
  output logic                   full_o,
  output logic                   cmd_valid_o,
  output aesi_pkg::cmd_t         cmd_o,
  input  wire logic              cmd_full_i
);
  import aesi_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic csi_q, csi_d, bad_q, bad_d, innum_q, innum_d, halt_q, halt_d;
  logic [ParamBits-1:0] acc_q, acc_d, p0_q, p0_d, p1_q, p1_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic mclr_q, mclr_d, mbad_q, mbad_d;
  logic [3:0] mset_q, mset_d;
  logic acc_en, start, is_final, pushing, short_seq;
  logic [7:0] b;
  logic [ParamBits+3:0] prod;
  localparam logic [ParamBits+3:0] SatMax = (ParamBits+4)'((64'd1 << ParamBits) - 1);

  assign full_o = cmd_full_i;
  assign acc_en = push_i && !cmd_full_i;
  assign b = in_word_i.seq_byte;
  assign start = in_word_i.seq_first || (idx_q == 2'd0);
  assign is_final = (b >= FinalLo) && (b <= FinalHi) && (b != ChLbr);
  assign prod = {4'b0, acc_q} * (ParamBits+4)'(10) + (ParamBits+4)'(b - ChZero);

  always_comb begin
    idx_d = idx_q; csi_d = csi_q; bad_d = bad_q; innum_d = innum_q; halt_d = halt_q;
    acc_d = acc_q; p0_d = p0_q; p1_d = p1_q; cnt_d = cnt_q;
    mclr_d = mclr_q; mset_d = mset_q; mbad_d = mbad_q;
    pushing = 1'b0;
    short_seq = 1'b0;
    if (start) begin
      cnt_d = '0; acc_d = '0; innum_d = 1'b0; halt_d = 1'b0; csi_d = 1'b0;
      bad_d = (b != ChEsc); idx_d = 2'd1; p0_d = '0; p1_d = '0;
      mclr_d = 1'b0; mset_d = '0; mbad_d = 1'b0;
    end else if (idx_q == 2'd1) begin
      idx_d = 2'd2;
      if (b == ChLbr) begin
        csi_d = 1'b1;
        if (in_word_i.seq_last) bad_d = 1'b1;
      end else if (!in_word_i.seq_last) begin
        bad_d = 1'b1;
      end else begin
        short_seq = 1'b1;
      end
    end else begin
      if (!csi_q) begin
        bad_d = 1'b1;
      end else if (is_final) begin
        pushing = innum_q;
        if (!in_word_i.seq_last) bad_d = 1'b1;
      end else if (b == ChSemi || b == ChLbr) begin
        pushing = innum_q;
        if (in_word_i.seq_last) bad_d = 1'b1;
      end else if (!innum_q && (b == ChEsc || b == ChQm)) begin
        if (in_word_i.seq_last) bad_d = 1'b1;
      end else begin
        if (!innum_q) begin
          innum_d = 1'b1;
        end
        if (innum_q && !halt_q && b >= ChZero && b <= ChNine) begin
          acc_d = (prod > SatMax) ? SatMax[ParamBits-1:0] : prod[ParamBits-1:0];
        end else if (!innum_q && b >= ChZero && b <= ChNine) begin
          acc_d = ParamBits'(b - ChZero);
          halt_d = 1'b0;
        end else begin
          if (!innum_q) acc_d = '0;
          halt_d = 1'b1;
        end
        if (in_word_i.seq_last) bad_d = 1'b1;
      end
    end
    if (pushing) begin
      if (cnt_q < CntW'(MaxParams)) begin
        if (cnt_q == CntW'(0)) p0_d = acc_q;
        if (cnt_q == CntW'(1)) p1_d = acc_q;
        if (!mbad_q) begin
          case (acc_q)
            ParamBits'(0): begin mclr_d = 1'b1; mset_d = '0; end
            ParamBits'(1): mset_d = mset_q | 4'b0001;
            ParamBits'(4): mset_d = mset_q | 4'b0010;
            ParamBits'(5): mset_d = mset_q | 4'b0100;
            ParamBits'(7): mset_d = mset_q | 4'b1000;
            default: mbad_d = 1'b1;
          endcase
        end
      end
      if (cnt_q < CntW'(MaxParams + 1)) cnt_d = cnt_q + CntW'(1);
      innum_d = 1'b0; acc_d = '0; halt_d = 1'b0;
    end
    if (in_word_i.seq_last) idx_d = 2'd0;
  end

  always_comb begin
    cmd_valid_o = acc_en && in_word_i.seq_last;
    cmd_o.fb = b;
    cmd_o.n = cnt_d;
    cmd_o.p0 = p0_d;
    cmd_o.p1 = p1_d;
    cmd_o.mclr = mclr_d;
    cmd_o.mset = mset_d;
    cmd_o.mbad = mbad_d;
    if (start || bad_d) cmd_o.kind = KindBad;
    else if (short_seq) cmd_o.kind = KindShort;
    else cmd_o.kind = KindCsi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; csi_q <= 1'b0; bad_q <= 1'b0; innum_q <= 1'b0; halt_q <= 1'b0;
      acc_q <= '0; cnt_q <= '0; mclr_q <= 1'b0; mset_q <= '0; mbad_q <= 1'b0;
    end else if (acc_en) begin
      idx_q <= idx_d; csi_q <= csi_d; bad_q <= bad_d; innum_q <= innum_d;
      halt_q <= halt_d; acc_q <= acc_d; cnt_q <= cnt_d;
      mclr_q <= mclr_d; mset_q <= mset_d; mbad_q <= mbad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_en) begin
      p0_q <= p0_d; p1_q <= p1_d;
    end
  end
endmodule
`default_nettype wire

// File: src/aesi_cmd_queue.sv
// Two-entry command queue between parser and executor.
`default_nettype none
module aesi_cmd_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_i,
  input  wire aesi_pkg::cmd_t wdata_i,
  output logic           full_o,
  output logic           valid_o,
  input  wire logic      rd_i,
  output aesi_pkg::cmd_t rdata_o
);
  import aesi_pkg::*;

  cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic do_wr, do_rd;

  assign full_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_wr = wr_i && !full_o;
  assign do_rd = rd_i && valid_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= ~wp_q;
      if (do_rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule
`default_nettype wire

// File: src/aesi_back.sv
// Executor: applies commands to terminal state and holds the result word.
`default_nettype none
module aesi_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [8:0]        cfg_data_i,
  input  wire logic              cmd_valid_i,
  input  wire aesi_pkg::cmd_t    cmd_i,
  output logic                   cmd_rd_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output aesi_pkg::out_word_t    out_word_o
);
  import aesi_pkg::*;

  logic [CfgW-1:0] w_q, h_q, we, he, wm1, hm1;
  logic [7:0] col_q, col_d, row_q, row_d, top_q, top_d, bot_q, bot_d;
  logic [3:0] attr_q, attr_d;
  logic [1:0] mode_q, mode_d;
  logic ov_q;
  out_word_t out_q;
  action_e act;
  logic [ParamBits-1:0] mv, p1m1, p0m1;
  logic [ParamBits:0] sum;

  function automatic logic [CfgW-1:0] eff(input logic [CfgW-1:0] d);
    if (d == '0) return CfgW'(1);
    if (d > CfgW'(256)) return CfgW'(256);
    return d;
  endfunction

  assign we = eff(w_q);
  assign he = eff(h_q);
  assign wm1 = we - CfgW'(1);
  assign hm1 = he - CfgW'(1);
  assign cmd_rd_o = cmd_valid_i && (!ov_q || pop_i);
  assign empty_o = !ov_q;
  assign out_word_o = out_q;
  assign mv = (cmd_i.n == '0 || cmd_i.p0 == '0) ? ParamBits'(1) : cmd_i.p0;
  assign p0m1 = cmd_i.p0 - ParamBits'(1);
  assign p1m1 = cmd_i.p1 - ParamBits'(1);

  always_comb begin
    col_d = col_q; row_d = row_q; top_d = top_q; bot_d = bot_q;
    attr_d = attr_q; mode_d = mode_q; act = ActInvalid;
    sum = '0;
    unique case (cmd_i.kind)
      KindShort: begin
        case (cmd_i.fb)
          8'h3d: begin mode_d[1] = 1'b1; act = ActUpdate; end
          8'h3e: begin mode_d[1] = 1'b0; act = ActUpdate; end
          8'h4d: begin
            if (row_q > top_q) begin row_d = row_q - 8'd1; act = ActUpdate; end
            else act = ActScrollDn;
          end
          default: act = ActInvalid;
        endcase
      end
      KindCsi: begin
        act = ActUpdate;
        case (cmd_i.fb)
          8'h41: row_d = ({{(ParamBits-8){1'b0}}, row_q} < mv) ? 8'd0 : row_q - mv[7:0];
          8'h42: begin
            sum = {{(ParamBits-7){1'b0}}, row_q} + {1'b0, mv};
            row_d = (sum > (ParamBits+1)'(hm1)) ? hm1[7:0] : sum[7:0];
          end
          8'h43: begin
            sum = {{(ParamBits-7){1'b0}}, col_q} + {1'b0, mv};
            col_d = (sum > (ParamBits+1)'(wm1)) ? wm1[7:0] : sum[7:0];
          end
          8'h44: col_d = ({{(ParamBits-8){1'b0}}, col_q} < mv) ? 8'd0 : col_q - mv[7:0];
          8'h48: begin
            if (cmd_i.n == '0) begin col_d = '0; row_d = '0; end
            else if (cmd_i.n != CntW'(2)) act = ActInvalid;
            else begin
              col_d = (cmd_i.p1 == '0) ? 8'd0 :
                      (p1m1 > ParamBits'(wm1)) ? wm1[7:0] : p1m1[7:0];
              row_d = (cmd_i.p0 == '0) ? 8'd0 :
                      (p0m1 > ParamBits'(hm1)) ? hm1[7:0] : p0m1[7:0];
            end
          end
          8'h4a: act = (cmd_i.p0 == '0) ? ActEraseEos :
                       (cmd_i.p0 == ParamBits'(2)) ? ActEraseAll : ActInvalid;
          8'h4b: act = ActEraseEol;
          8'h63: act = (cmd_i.p0 == '0) ? ActDaReply : ActInvalid;
          8'h68, 8'h6c: begin
            if (cmd_i.n != CntW'(1) || cmd_i.p0 != ParamBits'(1)) act = ActInvalid;
            else mode_d[0] = (cmd_i.fb == 8'h68);
          end
          8'h6d: begin
            if (cmd_i.n == '0) attr_d = '0;
            else attr_d = (cmd_i.mclr ? 4'b0 : attr_q) | cmd_i.mset;
            if (cmd_i.mbad) act = ActInvalid;
          end
          8'h72: begin
            if (cmd_i.n != CntW'(2)) begin top_d = 8'd1; bot_d = 8'd25; end
            else begin
              top_d = (cmd_i.p0 > ParamBits'(255)) ? 8'd255 : cmd_i.p0[7:0];
              bot_d = (cmd_i.p1 > ParamBits'(255)) ? 8'd255 : cmd_i.p1[7:0];
            end
          end
          default: act = ActUnhandled;
        endcase
      end
      default: act = ActInvalid;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= CfgW'(80); h_q <= CfgW'(25);
      col_q <= '0; row_q <= '0; attr_q <= '0; mode_q <= '0;
      top_q <= 8'd1; bot_q <= 8'd25; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgWidth) w_q <= cfg_data_i;
        if (cfg_idx_i == CfgHeight) h_q <= cfg_data_i;
      end
      if (cmd_rd_o) begin
        col_q <= col_d; row_q <= row_d; attr_q <= attr_d; mode_q <= mode_d;
        top_q <= top_d; bot_q <= bot_d; ov_q <= 1'b1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_rd_o) begin
      out_q <= '{action: act, cursor_col: col_d, cursor_row: row_d,
                 attr_bold: attr_d[0], attr_underline: attr_d[1], attr_blink: attr_d[2],
                 attr_reverse: attr_d[3], cursor_keys_app: mode_d[0],
                 keypad_app: mode_d[1], region_top: top_d, region_bottom: bot_d};
    end
  end
endmodule
`default_nettype wire

// File: src/ansi_escape_sequence_interpreter_core.sv
// Top level of the escape-sequence interpreter.
// Takes one sequence byte per cycle when full is low and delivers one result word per
// sequence: the parser writes each command into the command queue, and the executor applies
// it into its output register when free. The two-entry command queue and the executor's
// output register let bytes keep flowing while a result waits; full rises only once both
// queue entries and the result are held. Configuration resets to 80 columns by 25 rows.
`default_nettype none
module ansi_escape_sequence_interpreter_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  input  wire aesi_pkg::in_word_t in_word_i,
  output logic                 full,
  output logic                 empty,
  input  wire logic            pop,
  output aesi_pkg::out_word_t  out_word_o,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire logic [8:0]      cfg_data_i
);
  import aesi_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_valid, q_full, q_valid, q_rd;

  aesi_front u_front (
    .clk_i, .rst_ni, .push_i(push), .in_word_i, .full_o(full),
    .cmd_valid_o(f_valid), .cmd_o(f_cmd), .cmd_full_i(q_full)
  );

  aesi_cmd_queue u_queue (
    .clk_i, .rst_ni, .wr_i(f_valid), .wdata_i(f_cmd), .full_o(q_full),
    .valid_o(q_valid), .rd_i(q_rd), .rdata_o(q_cmd)
  );

  aesi_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_valid_i(q_valid), .cmd_i(q_cmd), .cmd_rd_o(q_rd),
    .empty_o(empty), .pop_i(pop), .out_word_o
  );
endmodule
`default_nettype wire
